// ===== hw/rtl/hads_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hads_pkg;

  // Fixed widths of the configuration registers and result fields.
  localparam int ROW_LEN_W  = 11;
  localparam int TARGET_W   = 7;
  localparam int ROW_CNT_W  = 16;
  localparam int INDEX_W    = 6;
  localparam int SHIFT_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_ROW     = 1024;
  localparam int DEF_MAX_COEFF   = 64;
  localparam int DEF_SAMPLE_BITS = 16;

  // Depth of the job queue between front and back.
  localparam int JOB_DEPTH = 4;

  // Register values after reset.
  localparam logic [ROW_LEN_W-1:0] RST_ROW_LENGTH   = 11'd64;
  localparam logic [TARGET_W-1:0]  RST_TARGET_COUNT = 7'd8;
  localparam logic [ROW_CNT_W-1:0] RST_ROW_COUNT    = 16'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_LENGTH   = 2'd0,
    REG_TARGET_COUNT = 2'd1,
    REG_ROW_COUNT    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [ROW_LEN_W-1:0] row_length;
    logic [TARGET_W-1:0]  target_count;
    logic [ROW_CNT_W-1:0] row_count;
  } cfg_t;

  // Control part of one job; the window sum travels next to it.
  typedef struct packed {
    logic [SHIFT_W-1:0] shift;
    logic [INDEX_W-1:0] idx;
    logic [INDEX_W-1:0] npad;
    logic               lrow;
    logic               lframe;
  } job_ctl_t;

  // Ceiling of log2 for a nonzero value: the bit length of x-1.
  function automatic logic [SHIFT_W-1:0] hads_clog2(input logic [ROW_LEN_W-1:0] x);
    logic [ROW_LEN_W-1:0] v;
    logic [SHIFT_W-1:0]   e;
    v = x - 11'd1;
    e = '0;
    for (int i = 0; i < ROW_LEN_W; i++) begin
      if (v[i]) begin
        e = SHIFT_W'(i + 1);
      end
    end
    return e;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hads_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hads_front
  import hads_pkg::*;
#(
  parameter int MAX_ROW     = DEF_MAX_ROW,
  parameter int MAX_COEFF   = DEF_MAX_COEFF,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int SUM_W       = SAMPLE_BITS + ROW_LEN_W + 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire cfg_t                          cfg,
  input  wire logic                          take,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  output logic                               job_push,
  output job_ctl_t                           job_ctl,
  output logic signed [SUM_W-1:0]            job_sum
);

  localparam logic [ROW_LEN_W-1:0] LEN_CAP =
      (MAX_ROW < 2047) ? ROW_LEN_W'(MAX_ROW) : 11'd2047;
  localparam logic [TARGET_W-1:0] TC_CAP = TARGET_W'(MAX_COEFF);

  logic [ROW_LEN_W-1:0]    sample_position;
  logic signed [SUM_W-1:0] window_sum;
  logic [ROW_CNT_W-1:0]    row_counter;

  logic [ROW_LEN_W-1:0]    len;
  logic [TARGET_W-1:0]     tc;
  logic [ROW_CNT_W-1:0]    rc;
  logic [SHIFT_W-1:0]      pe;
  logic [SHIFT_W-1:0]      te;
  logic [SHIFT_W-1:0]      k;
  logic                    pass;
  logic                    end_row;
  logic                    lframe;
  logic [ROW_LEN_W-1:0]    pos;
  logic [ROW_LEN_W:0]      wmask;
  logic                    wcomp;
  logic [ROW_LEN_W-1:0]    w_full;
  logic [INDEX_W-1:0]      w;
  logic [INDEX_W-1:0]      last_idx;
  logic signed [SUM_W-1:0] s_ext;
  logic signed [SUM_W-1:0] new_sum;
  logic                    emit;

  always_comb begin
    if (cfg.row_length == '0) begin
      len = 11'd1;
    end else if (cfg.row_length > LEN_CAP) begin
      len = LEN_CAP;
    end else begin
      len = cfg.row_length;
    end
    if (cfg.target_count == '0) begin
      tc = 7'd1;
    end else if (cfg.target_count > TC_CAP) begin
      tc = TC_CAP;
    end else begin
      tc = cfg.target_count;
    end
    rc = (cfg.row_count == '0) ? 16'd1 : cfg.row_count;

    pe   = hads_clog2(len);
    te   = hads_clog2({4'd0, tc});
    pass = (te >= pe);
    k    = pass ? '0 : pe - te;

    end_row = ({1'b0, sample_position} + 12'd1) >= {1'b0, len};
    pos     = end_row ? len - 11'd1 : sample_position;
    lframe  = end_row && (({1'b0, row_counter} + 17'd1) >= {1'b0, rc});

    wmask    = (12'd1 << k) - 12'd1;
    wcomp    = ((({1'b0, pos} + 12'd1) & wmask) == '0);
    w_full   = pos >> k;
    w        = w_full[INDEX_W-1:0];
    last_idx = INDEX_W'((7'd1 << te) - 7'd1);

    s_ext   = {{(SUM_W - SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};
    new_sum = window_sum + s_ext;
    emit    = pass || end_row || wcomp;

    job_push       = take && emit;
    job_ctl.shift  = k;
    job_ctl.idx    = pass ? pos[INDEX_W-1:0] : w;
    job_ctl.npad   = (end_row && !pass) ? last_idx - w : '0;
    job_ctl.lrow   = end_row;
    job_ctl.lframe = lframe;
    job_sum        = pass ? s_ext : new_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_position <= '0;
      window_sum      <= '0;
      row_counter     <= '0;
    end else if (take) begin
      window_sum <= emit ? '0 : new_sum;
      if (end_row) begin
        sample_position <= '0;
        row_counter     <= lframe ? '0 : row_counter + 16'd1;
      end else begin
        sample_position <= sample_position + 11'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hads_job_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hads_job_fifo
  import hads_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = JOB_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  full,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hads_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hads_back
  import hads_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int SUM_W       = SAMPLE_BITS + ROW_LEN_W + 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    job_valid,
  input  wire job_ctl_t                job_ctl,
  input  wire logic signed [SUM_W-1:0] job_sum,
  output logic                         job_pop,
  input  wire logic                    pop,
  output logic                         empty,
  output logic [SAMPLE_BITS-1:0]       coeff,
  output logic [INDEX_W-1:0]           coeff_index,
  output logic                         last_in_row,
  output logic                         last_in_frame,
  output logic                         last_of_run
);

  logic               out_valid;
  logic [INDEX_W-1:0] pad_left;
  logic [INDEX_W-1:0] pad_idx;
  logic               job_lrow;
  logic               job_lframe;

  logic                    load;
  logic signed [SUM_W-1:0] shifted;
  logic [SUM_W-SAMPLE_BITS:0] hi_bits;
  logic [SAMPLE_BITS-1:0]  mean;
  logic                    final_job;
  logic                    final_pad;

  always_comb begin
    load    = !out_valid || pop;
    job_pop = load && (pad_left == '0) && job_valid;

    // Floored mean, saturated to the sample range.
    shifted = job_sum >>> job_ctl.shift;
    hi_bits = shifted[SUM_W-1:SAMPLE_BITS-1];
    if ((&hi_bits) || !(|hi_bits)) begin
      mean = shifted[SAMPLE_BITS-1:0];
    end else if (shifted[SUM_W-1]) begin
      mean = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
    end else begin
      mean = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    end

    final_job = (job_ctl.npad == '0);
    final_pad = (pad_left == INDEX_W'(1));
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pad_left != '0) begin
        coeff         <= '0;
        coeff_index   <= pad_idx;
        last_in_row   <= job_lrow && final_pad;
        last_in_frame <= job_lframe && final_pad;
        last_of_run   <= final_pad;
        pad_idx       <= pad_idx + INDEX_W'(1);
      end else if (job_valid) begin
        coeff         <= mean;
        coeff_index   <= job_ctl.idx;
        last_in_row   <= job_ctl.lrow && final_job;
        last_in_frame <= job_ctl.lframe && final_job;
        last_of_run   <= final_job;
        pad_idx       <= job_ctl.idx + INDEX_W'(1);
        job_lrow      <= job_ctl.lrow;
        job_lframe    <= job_ctl.lframe;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pad_left  <= '0;
    end else if (load) begin
      if (pad_left != '0) begin
        out_valid <= 1'b1;
        pad_left  <= pad_left - INDEX_W'(1);
      end else if (job_valid) begin
        out_valid <= 1'b1;
        pad_left  <= job_ctl.npad;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  assign empty = !out_valid;

endmodule

`default_nettype wire

// ===== hw/rtl/haar_approximation_downsampler.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Payload
// input     in         push / full        sample
// result    out        pop / empty        coeff, coeff_index, last_in_row,
//                                         last_in_frame, last_of_run
// config    in         cfg_valid / ready  cfg_index, cfg_data
//
// The block takes one sample per cycle while the job queue has room. With the back idle, a
// result is registered in the job queue and then in the result register before the ports.
// A sample that ends a row with padding fills the result side with one result per window it
// causes (up to the coefficient count); full rises only when all four queue entries hold jobs.
// Reset is synchronous and active high; it clears the row state, the queue and the result
// register and loads the register defaults. Either side may stall; cfg_ready is always high.

module haar_approximation_downsampler
  import hads_pkg::*;
#(
  parameter int MAX_ROW     = DEF_MAX_ROW,
  parameter int MAX_COEFF   = DEF_MAX_COEFF,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire logic                          pop,
  output logic                               empty,
  output logic signed [SAMPLE_BITS-1:0]      coeff,
  output logic [INDEX_W-1:0]                 coeff_index,
  output logic                               last_in_row,
  output logic                               last_in_frame,
  output logic                               last_of_run,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data
);

  // The window sum needs room for a full row of extreme samples.
  localparam int SUM_W = SAMPLE_BITS + ROW_LEN_W + 1;
  localparam int JOB_W = $bits(job_ctl_t) + SUM_W;

  cfg_t cfg;

  logic                    take;
  logic                    job_push;
  job_ctl_t                push_ctl;
  logic signed [SUM_W-1:0] push_sum;
  logic [JOB_W-1:0]        rd_data;
  job_ctl_t                pop_ctl;
  logic signed [SUM_W-1:0] pop_sum;
  logic                    job_pop;
  logic                    q_empty;
  logic [SAMPLE_BITS-1:0]  coeff_bits;

  // Configuration writes are always taken; an index outside the list is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_length   <= RST_ROW_LENGTH;
      cfg.target_count <= RST_TARGET_COUNT;
      cfg.row_count    <= RST_ROW_COUNT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROW_LENGTH: begin
          cfg.row_length <= cfg_data[ROW_LEN_W-1:0];
        end
        REG_TARGET_COUNT: begin
          cfg.target_count <= cfg_data[TARGET_W-1:0];
        end
        REG_ROW_COUNT: begin
          cfg.row_count <= cfg_data[ROW_CNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // A sample transfers whenever the job queue has room, even if that sample
  // would produce no job; this keeps the full flag a plain queue status.
  assign take = push && !full;

  // The front tracks the row position and window sum and turns each sample
  // into at most one job: a coefficient plus a count of trailing pad windows.
  hads_front #(
    .MAX_ROW    (MAX_ROW),
    .MAX_COEFF  (MAX_COEFF),
    .SAMPLE_BITS(SAMPLE_BITS),
    .SUM_W      (SUM_W)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .take    (take),
    .sample  (sample),
    .job_push(job_push),
    .job_ctl (push_ctl),
    .job_sum (push_sum)
  );

  hads_job_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(JOB_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (job_push),
    .wr_data({push_ctl, push_sum}),
    .pop    (job_pop),
    .rd_data(rd_data),
    .full   (full),
    .empty  (q_empty)
  );

  assign pop_ctl = rd_data[JOB_W-1:SUM_W];
  assign pop_sum = rd_data[SUM_W-1:0];

  // The back scales the window sum and expands pad windows into the result
  // register, one result per cycle while that register is empty or being popped.
  hads_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .SUM_W      (SUM_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (!q_empty),
    .job_ctl      (pop_ctl),
    .job_sum      (pop_sum),
    .job_pop      (job_pop),
    .pop          (pop),
    .empty        (empty),
    .coeff        (coeff_bits),
    .coeff_index  (coeff_index),
    .last_in_row  (last_in_row),
    .last_in_frame(last_in_frame),
    .last_of_run  (last_of_run)
  );

  assign coeff = $signed(coeff_bits);

  // Only the final result of a run can close a row.
  a_row_ends_run: assert property (@(posedge clk) disable iff (rst)
    (!empty && last_in_row) |-> last_of_run)
    else $error("last_in_row without last_of_run");

  // A frame mark is always also a row mark.
  a_frame_is_row: assert property (@(posedge clk) disable iff (rst)
    (!empty && last_in_frame) |-> last_in_row)
    else $error("last_in_frame without last_in_row");

  // Pad windows follow their coefficient with no gap and count up.
  a_pad_follows: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !last_of_run) |=>
      (!empty && coeff == '0 && coeff_index == $past(coeff_index) + 6'd1))
    else $error("pad window missing or out of order");

  // Reset leaves nothing to deliver and room to take a sample.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("state not cleared by reset");

endmodule

`default_nettype wire
